// ===== src/sti_pkg.sv =====
`default_nettype none

package sti_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 24;
    localparam int MODE_BITS      = 3;
    localparam int CFG_INDEX_BITS = 3;

    // timestamp modes, unused codes behave as proportional
    typedef enum logic [MODE_BITS-1:0] {
        MODE_LINE         = 3'd0,
        MODE_MULTI_LINE   = 3'd1,
        MODE_PER_IFOV     = 3'd2,
        MODE_SINGLE       = 3'd3,
        MODE_PROPORTIONAL = 3'd4
    } mode_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_MODE            = 3'd0,
        REG_IFOV_WIDTH      = 3'd1,
        REG_IFOV_HEIGHT     = 3'd2,
        REG_IMAGE_WIDTH     = 3'd3,
        REG_IMAGE_HEIGHT    = 3'd4,
        REG_TIMESTAMP_COUNT = 3'd5
    } cfg_reg_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

// ===== src/sti_if.sv =====
`default_nettype none

// pixel coordinate channel
interface sti_pixel_if #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// timestamp index channel
interface sti_result_if #(
    parameter int COUNT_BITS = sti_pkg::COUNT_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] time_index;
    logic                  time_valid;

    modport source (output valid, output time_index, output time_valid, input ready);
    modport sink   (input valid, input time_index, input time_valid, output ready);
endinterface

// configuration write channel
interface sti_cfg_if #(
    parameter int DATA_BITS = sti_pkg::COUNT_BITS_DEF
);
    logic                              valid;
    logic                              ready;
    logic [sti_pkg::CFG_INDEX_BITS-1:0] index;
    logic [DATA_BITS-1:0]              data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/scan_timestamp_index.sv =====
`default_nettype none

// Maps a pixel (pixel_x, pixel_y) of a scanned image to the index of the timestamp
// that applies to it, with time_valid clear when the table is empty. One transaction
// enters per clock and one result leaves per clock while the sink takes results. The
// bit-per-stage dividers (ifov column, ifov row, blocks per line and the proportional
// spread) sit between a multiply stage in front and two stages of rounding, clamping
// and mode selection behind. The whole pipeline holds while a result waits on a
// stalled sink; pixel.ready is low only then. The configuration port is always ready;
// registers are to be written only while no transaction is in flight, which the
// block itself does not enforce.
module scan_timestamp_index #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sti_pkg::COUNT_BITS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    sti_cfg_if.sink       cfg,
    sti_pixel_if.sink     pixel,
    sti_result_if.source  result
);

    import sti_pkg::*;

    // divider stage count, product width and compare width
    localparam int SB     = max_int(COORD_BITS, COUNT_BITS);
    localparam int PROD_W = COORD_BITS + COUNT_BITS;
    localparam int PW     = COORD_BITS + SB;
    localparam int SUMW   = 2 * COORD_BITS + 1;
    localparam int CW     = max_int(SUMW, COUNT_BITS);

    // configuration registers
    logic [MODE_BITS-1:0]  mode_reg;
    logic [COORD_BITS-1:0] ifov_width_reg;
    logic [COORD_BITS-1:0] ifov_height_reg;
    logic [COORD_BITS-1:0] image_width_reg;
    logic [COORD_BITS-1:0] image_height_reg;
    logic [COUNT_BITS-1:0] count_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_LINE;
            ifov_width_reg   <= COORD_BITS'(1);
            ifov_height_reg  <= COORD_BITS'(1);
            image_width_reg  <= COORD_BITS'(1);
            image_height_reg <= COORD_BITS'(1);
            count_reg        <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MODE:            mode_reg         <= cfg.data[MODE_BITS-1:0];
                REG_IFOV_WIDTH:      ifov_width_reg   <= cfg.data[COORD_BITS-1:0];
                REG_IFOV_HEIGHT:     ifov_height_reg  <= cfg.data[COORD_BITS-1:0];
                REG_IMAGE_WIDTH:     image_width_reg  <= cfg.data[COORD_BITS-1:0];
                REG_IMAGE_HEIGHT:    image_height_reg <= cfg.data[COORD_BITS-1:0];
                REG_TIMESTAMP_COUNT: count_reg        <= cfg.data[COUNT_BITS-1:0];
                default:             ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // values derived from configuration, stable while transactions are in flight
    logic [COORD_BITS-1:0] fw;        // ifov width, zero taken as one
    logic [COORD_BITS-1:0] fh;        // ifov height, zero taken as one
    logic [COORD_BITS-1:0] den;       // image height minus one, or one when the height is at most one; never zero
    logic [COORD_BITS-1:0] ih_m1;
    logic [COORD_BITS-1:0] iw_m1;
    logic                  iw_zero;
    logic                  ih_small;
    logic [COUNT_BITS-1:0] last;

    assign fw       = (ifov_width_reg == '0) ? COORD_BITS'(1) : ifov_width_reg;
    assign fh       = (ifov_height_reg == '0) ? COORD_BITS'(1) : ifov_height_reg;
    assign ih_small = (image_height_reg <= COORD_BITS'(1));
    assign ih_m1    = image_height_reg - COORD_BITS'(1);
    assign den      = ih_small ? COORD_BITS'(1) : ih_m1;
    assign iw_m1    = image_width_reg - COORD_BITS'(1);
    assign iw_zero  = (image_width_reg == '0);
    assign last     = count_reg - COUNT_BITS'(1);

    // whole pipeline moves unless a finished result is stuck at the output
    logic res_valid_reg;
    logic advance;

    assign advance     = !res_valid_reg || result.ready;
    assign pixel.ready = advance;

    // stage 0: capture the transaction and form y * (count - 1)
    logic                  v0_reg;
    logic [COORD_BITS-1:0] x0_reg;
    logic [COORD_BITS-1:0] y0_reg;
    logic [PROD_W-1:0]     prod0_reg;
    logic [PROD_W-1:0]     prod0_next;

    assign prod0_next = PROD_W'(pixel.pixel_y) * PROD_W'(last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x0_reg    <= pixel.pixel_x;
            y0_reg    <= pixel.pixel_y;
            prod0_reg <= prod0_next;
        end
    end

    // divider lanes
    logic [PW-1:0]         prod_wide;
    logic [SB-1:0]         qx;
    logic [SB-1:0]         qy;
    logic [SB-1:0]         qb;
    logic [SB-1:0]         qp;
    logic [COORD_BITS-1:0] rx_unused_free;
    logic [COORD_BITS-1:0] ry_unused_free;
    logic [COORD_BITS-1:0] rb_unused_free;
    logic [COORD_BITS-1:0] rp;

    assign prod_wide = PW'(prod0_reg);

    // column within the line of ifov blocks
    sti_div #(.QBITS(SB), .DBITS(COORD_BITS)) u_div_x (
        .clk     (clk),
        .en      (advance),
        .hi      ('0),
        .lo      (SB'(x0_reg)),
        .divisor (fw),
        .quo     (qx),
        .rem     (rx_unused_free)
    );

    // row of ifov blocks
    sti_div #(.QBITS(SB), .DBITS(COORD_BITS)) u_div_y (
        .clk     (clk),
        .en      (advance),
        .hi      ('0),
        .lo      (SB'(y0_reg)),
        .divisor (fh),
        .quo     (qy),
        .rem     (ry_unused_free)
    );

    // blocks per line minus one: (image_width - 1) / ifov_width
    sti_div #(.QBITS(SB), .DBITS(COORD_BITS)) u_div_blocks (
        .clk     (clk),
        .en      (advance),
        .hi      ('0),
        .lo      (SB'(iw_m1)),
        .divisor (fw),
        .quo     (qb),
        .rem     (rb_unused_free)
    );

    // proportional spread; only meaningful when y is below image_height - 1
    sti_div #(.QBITS(SB), .DBITS(COORD_BITS)) u_div_prop (
        .clk     (clk),
        .en      (advance),
        .hi      (prod_wide[PW-1:SB]),
        .lo      (prod_wide[SB-1:0]),
        .divisor (den),
        .quo     (qp),
        .rem     (rp)
    );

    // valid and line number travel alongside the dividers
    logic                  vd_reg [SB];
    logic [COORD_BITS-1:0] yd_reg [SB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SB; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vd_reg[0] <= v0_reg;
            for (int i = 1; i < SB; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            yd_reg[0] <= y0_reg;
            for (int i = 1; i < SB; i++)
            begin
                yd_reg[i] <= yd_reg[i-1];
            end
        end
    end

    // stage 1: block offset product, proportional rounding, line clamp
    logic [COORD_BITS-1:0]   y_late;
    logic [COORD_BITS-1:0]   blocks;
    logic                    y_beyond;
    logic                    round_up;
    logic [COUNT_BITS-1:0]   prop1_next;
    logic [COORD_BITS-1:0]   line1_next;
    logic [2*COORD_BITS-1:0] pos1_next;

    logic                    v1_reg;
    logic [2*COORD_BITS-1:0] pos1_reg;
    logic [COORD_BITS-1:0]   qx1_reg;
    logic [COORD_BITS-1:0]   qy1_reg;
    logic [COUNT_BITS-1:0]   prop1_reg;
    logic [COORD_BITS-1:0]   line1_reg;

    assign y_late    = yd_reg[SB-1];
    assign blocks    = iw_zero ? COORD_BITS'(1) : (qb[COORD_BITS-1:0] + COORD_BITS'(1));
    assign pos1_next = (2*COORD_BITS)'(qy[COORD_BITS-1:0]) * (2*COORD_BITS)'(blocks);

    // round half up: remainder at least half the divisor
    assign y_beyond = (y_late >= den);
    assign round_up = ({rp, 1'b0} >= {1'b0, den});

    always_comb
    begin
        if (ih_small)
        begin
            prop1_next = '0;
        end
        else if (y_beyond)
        begin
            prop1_next = last;
        end
        else
        begin
            prop1_next = qp[COUNT_BITS-1:0] + COUNT_BITS'(round_up);
        end
    end

    assign line1_next = (y_late > ih_m1) ? ih_m1 : y_late;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= vd_reg[SB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pos1_reg  <= pos1_next;
            qx1_reg   <= qx[COORD_BITS-1:0];
            qy1_reg   <= qy[COORD_BITS-1:0];
            prop1_reg <= prop1_next;
            line1_reg <= line1_next;
        end
    end

    // stage 2: clamp, pick by mode, output register
    logic [CW-1:0]         last_w;
    logic [CW-1:0]         sum_w;
    logic [CW-1:0]         qy_w;
    logic [CW-1:0]         ifov_w;
    logic [CW-1:0]         multi_w;
    logic [CW-1:0]         pick_w;
    logic                  line_exact;
    logic [COUNT_BITS-1:0] idx_next;
    logic                  tv_next;

    logic [COUNT_BITS-1:0] idx_reg;
    logic                  tv_reg;

    assign last_w     = CW'(last);
    assign sum_w      = CW'(pos1_reg) + CW'(qx1_reg);
    assign qy_w       = CW'(qy1_reg);
    assign ifov_w     = (sum_w > last_w) ? last_w : sum_w;
    assign multi_w    = (qy_w > last_w) ? last_w : qy_w;
    assign line_exact = (CW'(count_reg) == CW'(image_height_reg));

    always_comb
    begin
        unique case (mode_reg)
            MODE_LINE:       pick_w = line_exact ? CW'(line1_reg) : CW'(prop1_reg);
            MODE_MULTI_LINE: pick_w = multi_w;
            MODE_PER_IFOV:   pick_w = ifov_w;
            MODE_SINGLE:     pick_w = '0;
            default:         pick_w = CW'(prop1_reg);  // proportional and unused codes
        endcase
    end

    // empty table is invalid, a single entry is always index 0
    assign tv_next  = (count_reg != '0);
    assign idx_next = (count_reg > COUNT_BITS'(1)) ? pick_w[COUNT_BITS-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            idx_reg <= idx_next;
            tv_reg  <= tv_next;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.time_index = idx_reg;
    assign result.time_valid = tv_reg;

endmodule

`default_nettype wire

// ===== src/sti_div.sv =====
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
// dividend is {hi, lo}; hi must be below divisor; divisor held stable while busy
module sti_div #(
    parameter int QBITS = 24,
    parameter int DBITS = 16
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [DBITS-1:0] hi,
    input  wire logic [QBITS-1:0] lo,
    input  wire logic [DBITS-1:0] divisor,
    output logic      [QBITS-1:0] quo,
    output logic      [DBITS-1:0] rem
);

    logic [DBITS-1:0] rem_reg [QBITS];
    logic [QBITS-1:0] quo_reg [QBITS];
    logic [QBITS-1:0] lo_reg  [QBITS-1];

    generate
        for (genvar i = 0; i < QBITS; i++) begin : g_step
            logic [DBITS-1:0] rem_in;
            logic [QBITS-1:0] lo_in;
            logic [QBITS-1:0] quo_in;
            logic [DBITS:0]   trial;
            logic             take;
            logic [DBITS-1:0] rem_next;
            logic [QBITS-1:0] quo_next;

            if (i == 0) begin : g_first
                assign rem_in = hi;
                assign lo_in  = lo;
                assign quo_in = '0;
            end
            else begin : g_next
                assign rem_in = rem_reg[i-1];
                assign lo_in  = lo_reg[i-1];
                assign quo_in = quo_reg[i-1];
            end

            assign trial    = {rem_in, lo_in[QBITS-1]};
            assign take     = (trial >= {1'b0, divisor});
            assign rem_next = take ? DBITS'(trial - {1'b0, divisor}) : trial[DBITS-1:0];
            assign quo_next = {quo_in[QBITS-2:0], take};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    quo_reg[i] <= quo_next;
                end
            end

            if (i < QBITS - 1) begin : g_shift
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        lo_reg[i] <= {lo_in[QBITS-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign quo = quo_reg[QBITS-1];
    assign rem = rem_reg[QBITS-1];

endmodule

`default_nettype wire

// ===== dv/timestamp_index_check.sv =====
`default_nettype none

// watches the three channels, predicts each timestamp index and compares results in order
module timestamp_index_check #(
    parameter int COORD_BITS = sti_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = sti_pkg::COUNT_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sti_cfg_if        cfg,
    sti_pixel_if      pixel,
    sti_result_if     result,
    output int        mismatch_count,
    output int        stamps_in_flight,
    output int        stamps_checked
);
    import sti_pkg::*;

    typedef struct packed {
        logic [COUNT_BITS-1:0] index;
        logic                  valid;
    } stamp_t;

    stamp_t expected_stamps[$];

    // shadow copy of the register file
    logic [MODE_BITS-1:0]  mode_q;
    logic [COORD_BITS-1:0] ifov_w_q;
    logic [COORD_BITS-1:0] ifov_h_q;
    logic [COORD_BITS-1:0] img_w_q;
    logic [COORD_BITS-1:0] img_h_q;
    logic [COUNT_BITS-1:0] count_q;

    // spread of the table over the image height, exact half rounds up
    function automatic longint unsigned spread_index(longint unsigned y, longint unsigned last);
        longint unsigned den;
        longint unsigned prod;
        longint unsigned q;
        longint unsigned r;
        if (img_h_q <= 1)
            return 0;
        den  = img_h_q - 1;
        prod = y * last;
        q    = prod / den;
        r    = prod % den;
        if (r >= den - r)
            q++;
        return (q > last) ? last : q;
    endfunction

    function automatic stamp_t predict_stamp(logic [COORD_BITS-1:0] px,
                                             logic [COORD_BITS-1:0] py);
        longint unsigned x;
        longint unsigned y;
        longint unsigned fw;
        longint unsigned fh;
        longint unsigned cnt;
        longint unsigned h;
        longint unsigned last;
        longint unsigned idx;
        longint unsigned blocks;
        stamp_t s;
        x   = px;
        y   = py;
        fw  = (ifov_w_q == 0) ? 1 : ifov_w_q;
        fh  = (ifov_h_q == 0) ? 1 : ifov_h_q;
        cnt = count_q;
        h   = img_h_q;
        idx = 0;
        if (cnt == 0)
            return '0;
        last = cnt - 1;
        if (cnt > 1)
        begin
            case (mode_q)
                MODE_LINE:
                begin
                    if (cnt == h)
                        idx = (y > h - 1) ? h - 1 : y;
                    else
                        idx = spread_index(y, last);
                end
                MODE_MULTI_LINE:
                    idx = y / fh;
                MODE_PER_IFOV:
                begin
                    blocks = (img_w_q + fw - 1) / fw;
                    if (blocks < 1)
                        blocks = 1;
                    idx = (y / fh) * blocks + x / fw;
                end
                MODE_SINGLE:
                    idx = 0;
                default:
                    idx = spread_index(y, last);
            endcase
            if (idx > last)
                idx = last;
        end
        s.index = idx[COUNT_BITS-1:0];
        s.valid = 1'b1;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        stamp_t want;
        if (!rst_n)
        begin
            mode_q   = MODE_LINE;
            ifov_w_q = 1;
            ifov_h_q = 1;
            img_w_q  = 1;
            img_h_q  = 1;
            count_q  = '0;
            expected_stamps.delete();
            mismatch_count   = 0;
            stamps_in_flight = 0;
            stamps_checked   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MODE:            mode_q   = cfg.data[MODE_BITS-1:0];
                    REG_IFOV_WIDTH:      ifov_w_q = cfg.data[COORD_BITS-1:0];
                    REG_IFOV_HEIGHT:     ifov_h_q = cfg.data[COORD_BITS-1:0];
                    REG_IMAGE_WIDTH:     img_w_q  = cfg.data[COORD_BITS-1:0];
                    REG_IMAGE_HEIGHT:    img_h_q  = cfg.data[COORD_BITS-1:0];
                    REG_TIMESTAMP_COUNT: count_q  = cfg.data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (pixel.valid && pixel.ready)
                expected_stamps.insert(expected_stamps.size(),
                                       predict_stamp(pixel.pixel_x, pixel.pixel_y));
            if (result.valid && result.ready)
            begin
                if (expected_stamps.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("unexpected result: index %0d valid %0b",
                                 result.time_index, result.time_valid);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    if (result.time_index !== want.index || result.time_valid !== want.valid)
                    begin
                        if (mismatch_count < 10)
                            $display({"result %0d mismatch: expected index %0d valid %0b,",
                                      " got index %0d valid %0b"},
                                     stamps_checked, want.index, want.valid,
                                     result.time_index, result.time_valid);
                        mismatch_count++;
                    end
                    stamps_checked++;
                end
            end
            stamps_in_flight = expected_stamps.size();
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_scan_timestamp_index.sv =====
`default_nettype none

module tb_scan_timestamp_index;
    import sti_pkg::*;

    localparam int COORD_BITS  = COORD_BITS_DEF;
    localparam int COUNT_BITS  = COUNT_BITS_DEF;
    // pipeline depth as given by the block: dividers plus multiply, rounding and output stages
    localparam int PIPE_DEPTH  = max_int(COORD_BITS, COUNT_BITS) + 3;
    localparam int TOTAL_ITEMS = 1550;
    localparam int LONG_HOLD   = 400;
    // cycles with no transaction on any channel before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    localparam logic [MODE_BITS-1:0] MODE_CODE_MAX = '1;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic clk;
    logic rst_n;

    sti_cfg_if    #(.DATA_BITS(COUNT_BITS))   cfg_bus ();
    sti_pixel_if  #(.COORD_BITS(COORD_BITS))  pixel_bus ();
    sti_result_if #(.COUNT_BITS(COUNT_BITS))  result_bus ();

    int mismatches;
    int in_flight;
    int results_checked;

    // knobs shared between the sender flow and the result sink
    bit send_gaps;
    bit sink_stalls;
    bit long_hold_req;

    int pixels_sent;
    int settings_applied;

    // current register values, used to shape pixel coordinates
    int cur_w;
    int cur_h;

    scan_timestamp_index #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .pixel  (pixel_bus),
        .result (result_bus)
    );

    timestamp_index_check #(
        .COORD_BITS (COORD_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) index_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_bus),
        .pixel            (pixel_bus),
        .result           (result_bus),
        .mismatch_count   (mismatches),
        .stamps_in_flight (in_flight),
        .stamps_checked   (results_checked)
    );

    // 20 unit period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ifov and image sizes: zero, one and all-ones included on purpose
    function automatic logic [COORD_BITS-1:0] pick_size();
        case ($urandom_range(0, 11))
            0:          return '0;
            1:          return 1;
            2:          return COORD_MAX;
            3, 4, 5:    return COORD_BITS'($urandom_range(2, 16));
            6, 7, 8, 9: return COORD_BITS'($urandom_range(17, 1023));
            default:    return COORD_BITS'($urandom());
        endcase
    endfunction

    // table size; equal to image height often enough to hit the exact line case
    function automatic logic [COUNT_BITS-1:0] pick_count(int h);
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return 1;
            2:       return COUNT_MAX;
            3, 4:    return COUNT_BITS'(h);
            5, 6, 7: return COUNT_BITS'($urandom_range(2, 64));
            8, 9:    return COUNT_BITS'($urandom_range(65, 70000));
            10:      return COUNT_BITS'(($urandom_range(0, 1) != 0) ? h + 1 : h - 1);
            default: return COUNT_BITS'($urandom());
        endcase
    endfunction

    // result sink: random stalls, plus one long hold on request
    initial
    begin : result_sink
        int stall_left;
        int len;
        result_bus.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                len = (sink_stalls && $urandom_range(0, 3) == 0) ? gap_len() : 0;
                if (len > 0)
                begin
                    stall_left = len - 1;
                    result_bus.ready <= 1'b0;
                end
                else
                    result_bus.ready <= 1'b1;
            end
        end
    end

    // hang detection: any transaction on any channel restarts the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles, %0d results outstanding", QUIET_LIMIT, in_flight);
        $display("Regression FAIL");
        $finish;
    end

    // one register write transaction
    task automatic write_reg(cfg_reg_t which, logic [COUNT_BITS-1:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= which;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // drop valid, wait for every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        pixel_bus.valid <= 1'b0;
        while (in_flight != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4)
            @(negedge clk);
    endtask

    // registers are only rewritten with the pipeline empty
    task automatic configure(logic [MODE_BITS-1:0] m, logic [COORD_BITS-1:0] iw,
                             logic [COORD_BITS-1:0] ih, logic [COORD_BITS-1:0] w,
                             logic [COORD_BITS-1:0] h, logic [COUNT_BITS-1:0] cnt);
        wait_idle();
        write_reg(REG_MODE, COUNT_BITS'(m));
        write_reg(REG_IFOV_WIDTH, COUNT_BITS'(iw));
        write_reg(REG_IFOV_HEIGHT, COUNT_BITS'(ih));
        write_reg(REG_IMAGE_WIDTH, COUNT_BITS'(w));
        write_reg(REG_IMAGE_HEIGHT, COUNT_BITS'(h));
        write_reg(REG_TIMESTAMP_COUNT, cnt);
        cur_w = int'(w);
        cur_h = int'(h);
        settings_applied++;
    endtask

    // one pixel transaction, with an optional idle gap in front
    task automatic send_pixel(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
        int gap;
        gap = send_gaps ? gap_len() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            // junk on the bus while idle
            pixel_bus.valid   <= 1'b0;
            pixel_bus.pixel_x <= COORD_BITS'($urandom());
            pixel_bus.pixel_y <= COORD_BITS'($urandom());
            repeat (gap)
                @(negedge clk);
        end
        pixel_bus.valid   <= 1'b1;
        pixel_bus.pixel_x <= x;
        pixel_bus.pixel_y <= y;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // mix of full-range, corner and in-image coordinates
    task automatic send_random_pixel();
        int span_x;
        int span_y;
        span_x = (cur_w + 1 > int'(COORD_MAX)) ? int'(COORD_MAX) : cur_w + 1;
        span_y = (cur_h + 1 > int'(COORD_MAX)) ? int'(COORD_MAX) : cur_h + 1;
        case ($urandom_range(0, 9))
            0, 1, 2: send_pixel(COORD_BITS'($urandom()), COORD_BITS'($urandom()));
            3:       send_pixel(($urandom_range(0, 1) != 0) ? COORD_MAX : '0,
                                ($urandom_range(0, 1) != 0) ? COORD_MAX : '0);
            default: send_pixel(COORD_BITS'($urandom_range(0, span_x)),
                                COORD_BITS'($urandom_range(0, span_y)));
        endcase
    endtask

    initial
    begin : stimulus
        int phase_no;
        int n;
        logic [MODE_BITS-1:0]  m;
        logic [COORD_BITS-1:0] iw;
        logic [COORD_BITS-1:0] ih;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;

        // everything known from time zero, reset held low and then released
        rst_n             = 1'b0;
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = REG_MODE;
        cfg_bus.data      = '0;
        pixel_bus.valid   = 1'b0;
        pixel_bus.pixel_x = '0;
        pixel_bus.pixel_y = '0;
        send_gaps         = 1'b1;
        sink_stalls       = 1'b1;
        long_hold_req     = 1'b0;
        pixels_sent       = 0;
        settings_applied  = 0;
        cur_w             = 1;
        cur_h             = 1;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // empty table straight out of reset: valid clear, index zero
        send_pixel('0, '0);
        send_pixel(COORD_MAX, COORD_MAX);

        // single entry gives index 0 even far outside the ifov grid
        configure(MODE_PER_IFOV, 3, 2, 10, 4, 1);
        send_pixel(COORD_MAX, COORD_MAX);

        // line mode, count equals height: y passed through, clamped at the last line
        configure(MODE_LINE, 1, 1, 5, 100, 100);
        send_pixel(0, 0);
        send_pixel(4, 99);
        send_pixel(1, 100);
        send_pixel(COORD_MAX, COORD_MAX);

        // line mode, count differs from height: falls back to proportional
        configure(MODE_LINE, 1, 1, 5, 100, 50);
        send_pixel(0, 1);
        send_pixel(0, 2);
        send_pixel(0, 99);

        // multi line with a zero ifov height, which acts as one
        configure(MODE_MULTI_LINE, 1, 0, 5, 100, COUNT_MAX);
        send_pixel(0, 5);
        send_pixel(COORD_MAX, COORD_MAX);

        // per ifov with a partial block at the end of the line, largest table
        configure(MODE_PER_IFOV, 3, 2, 10, 4, COUNT_MAX);
        send_pixel(9, 5);
        send_pixel(COORD_MAX, COORD_MAX);
        send_pixel(0, 0);

        // per ifov with zero ifov width and zero image width: one block per line
        configure(MODE_PER_IFOV, 0, 0, 0, 4, 20);
        send_pixel(7, 3);

        // single image mode
        configure(MODE_SINGLE, 1, 1, 1, 1, 5);
        send_pixel(COORD_MAX, COORD_MAX);

        // proportional, y=1 lands on an exact half and rounds up, y=3 is past the image
        configure(MODE_PROPORTIONAL, 1, 1, 1, 3, 4);
        send_pixel(0, 0);
        send_pixel(0, 1);
        send_pixel(0, 2);
        send_pixel(0, 3);

        // proportional with a one-line and a zero-line image: always 0
        configure(MODE_PROPORTIONAL, 1, 1, 1, 1, 4);
        send_pixel(0, 7);
        configure(MODE_PROPORTIONAL, 1, 1, 1, 0, 4);
        send_pixel(0, 7);

        // an unused mode code behaves as proportional
        configure(MODE_CODE_MAX, 1, 1, 1, COORD_MAX, COUNT_MAX);
        send_pixel(0, COORD_MAX);
        send_pixel(0, 16'h8000);

        // ---- random part: a fresh register setting per phase ----
        phase_no = 0;
        while (pixels_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                m = MODE_BITS'($urandom_range(MODE_PROPORTIONAL + 1, MODE_CODE_MAX));
            else
                m = MODE_BITS'($urandom_range(MODE_LINE, MODE_PROPORTIONAL));
            iw = pick_size();
            ih = pick_size();
            w  = pick_size();
            h  = pick_size();
            configure(m, iw, ih, w, h, pick_count(int'(h)));

            // some phases run back to back on one or both sides
            send_gaps   = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            n = $urandom_range(40, 75);

            // long sink hold with the sender pushing flat out: pipeline fills, input stalls
            if (phase_no == 2)
            begin
                send_gaps     = 1'b0;
                long_hold_req = 1'b1;
                n = 120;
            end

            for (int i = 0; i < n; i++)
            begin
                // once, mid-phase, stop sending until every result is back
                if (phase_no == 5 && i == n / 2)
                begin
                    @(negedge clk);
                    pixel_bus.valid <= 1'b0;
                    while (in_flight != 0)
                        @(negedge clk);
                end
                send_random_pixel();
            end
            phase_no++;
        end

        wait_idle();

        $display("sent %0d pixel transactions over %0d register settings, modes 0 to 7",
                 pixels_sent, settings_applied);
        $display("compared %0d results, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/sti_pkg.sv
src/sti_if.sv
src/sti_div.sv
src/scan_timestamp_index.sv
dv/timestamp_index_check.sv
dv/tb_scan_timestamp_index.sv
